// ----- design/itot_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package itot_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W  = 16;
  localparam int CYCLES_W  = 16;
  localparam int COUNT_W   = 15;
  localparam int DIFF_W    = 17;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int MAG_W     = 32;
  localparam int DEN_W     = 16;
  localparam int QUO_W     = MAG_W + 1;
  localparam int DELAY_W   = PROD_W;
  localparam int DIV_CNT_W = $clog2(MAG_W);
  localparam int CFG_IDX_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_CEILING = COUNT_W'(32000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRIP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_PICKUP    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_FULL      = CFG_IDX_W'(4);

  // Operation codes.
  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic                        operation;
    logic signed [SAMPLE_W-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic trip;
    logic picked_up;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_CLAMP,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- design/itot_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module itot_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire itot_pkg::div_req_t req,
  output itot_pkg::div_rsp_t    rsp
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [itot_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [itot_pkg::MAG_W-1:0]         quo_r, quo_nxt;
  logic [itot_pkg::DEN_W-1:0]         rem_r, rem_nxt;
  logic [itot_pkg::DEN_W-1:0]         den_r, den_nxt;
  logic [itot_pkg::DEN_W:0]           rem_sh;
  logic [itot_pkg::DEN_W:0]           rem_sub;
  logic                               ge;

  assign rem_sh  = {rem_r, quo_r[itot_pkg::MAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[itot_pkg::MAG_W-2:0], ge};
      rem_nxt = ge ? rem_sub[itot_pkg::DEN_W-1:0] : rem_sh[itot_pkg::DEN_W-1:0];
      cnt_nxt = cnt_r + itot_pkg::DIV_CNT_W'(1);
      if (cnt_r == itot_pkg::DIV_CNT_W'(itot_pkg::MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ----- design/inverse_time_overload_trip_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A clear item or a sample at or below pickup goes from acceptance straight to the finish
// state; a sample above pickup passes through multiply, setup, 32 divider steps, clamp and
// finish, the divide being done by the one-bit-per-cycle divider.
// No new item is taken before the last one is through; in_ready is high only while the sequencer idles.
// A finished result waits in the output register while the next item is already taken.
// Reset (rst_n low at a clock edge) zeroes all configuration registers and protection state.
module inverse_time_overload_trip_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire itot_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output itot_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [itot_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [itot_pkg::CYCLES_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [itot_pkg::CYCLES_W-1:0]        min_trip_r;
  logic [itot_pkg::CYCLES_W-1:0]        max_trip_r;
  logic [itot_pkg::CYCLES_W-1:0]        release_cycles_r;
  logic signed [itot_pkg::SAMPLE_W-1:0] pickup_level_r;
  logic signed [itot_pkg::SAMPLE_W-1:0] full_level_r;

  // Protection state.
  logic [itot_pkg::COUNT_W-1:0]         operate_count_r;
  logic [itot_pkg::CYCLES_W-1:0]        release_count_r;
  logic                                 pickup_flag_r;
  logic                                 trip_flag_r;

  // Sequencer and item working registers.
  itot_pkg::state_t                     state_r, state_nxt;
  logic                                 op_r;
  logic                                 hit_r;
  logic signed [itot_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [itot_pkg::PROD_W-1:0]   prod_r;
  logic                                 den_neg_r;
  logic [itot_pkg::DEN_W-1:0]           den_mag_r;
  logic                                 q_neg_r;
  logic signed [itot_pkg::QUO_W-1:0]    q_r;
  logic [itot_pkg::CYCLES_W-1:0]        delay_r;
  logic                                 out_valid_r;
  itot_pkg::out_item_t                  out_data_r;

  // Sequencer strobes.
  logic accept, do_mul, do_dstart, ld_q, ld_delay, commit;

  itot_pkg::div_req_t div_req;
  itot_pkg::div_rsp_t div_rsp;

  // Datapath signals.
  logic                                 in_hit;
  logic signed [itot_pkg::DIFF_W-1:0]   diff_hl;
  logic signed [itot_pkg::DIFF_W-1:0]   diff_fs;
  logic signed [itot_pkg::DIFF_W-1:0]   den;
  logic signed [itot_pkg::PROD_W-1:0]   prod;
  logic [itot_pkg::PROD_W-1:0]          prod_neg;
  logic [itot_pkg::DIFF_W-1:0]          den_neg_val;
  logic signed [itot_pkg::DELAY_W-1:0]  lo_ext;
  logic signed [itot_pkg::DELAY_W-1:0]  hi_ext;
  logic signed [itot_pkg::DELAY_W-1:0]  dly_raw;
  logic signed [itot_pkg::DELAY_W-1:0]  dly_lo;
  logic signed [itot_pkg::DELAY_W-1:0]  dly_clamped;
  logic [itot_pkg::MAG_W:0]             quo_ext;
  logic [itot_pkg::COUNT_W-1:0]         op_cnt_inc;
  logic [itot_pkg::CYCLES_W-1:0]        rel_dec;

  // Configuration writes are always taken; the host must write only while the block is idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_trip_r       <= '0;
      max_trip_r       <= '0;
      release_cycles_r <= '0;
      pickup_level_r   <= '0;
      full_level_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        itot_pkg::CFG_MIN_TRIP: min_trip_r       <= cfg_data;
        itot_pkg::CFG_MAX_TRIP: max_trip_r       <= cfg_data;
        itot_pkg::CFG_RELEASE:  release_cycles_r <= cfg_data;
        itot_pkg::CFG_PICKUP:   pickup_level_r   <= $signed(cfg_data);
        itot_pkg::CFG_FULL:     full_level_r     <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // A sample strictly above pickup starts the timing path.
  assign in_hit = (in_data.sample > pickup_level_r);

  // Multiply stage: (max - min) * (full - sample), and the divisor full - pickup.
  assign diff_hl = $signed({1'b0, max_trip_r}) - $signed({1'b0, min_trip_r});
  assign diff_fs = $signed({full_level_r[itot_pkg::SAMPLE_W-1], full_level_r})
                 - $signed({sample_r[itot_pkg::SAMPLE_W-1], sample_r});
  assign den     = $signed({full_level_r[itot_pkg::SAMPLE_W-1], full_level_r})
                 - $signed({pickup_level_r[itot_pkg::SAMPLE_W-1], pickup_level_r});
  assign prod    = diff_hl * diff_fs;
  assign den_neg_val = -den;

  // The divider works on magnitudes; the sign is put back on the quotient.
  assign prod_neg = -prod_r;
  assign div_req.start    = do_dstart;
  assign div_req.dividend = prod_r[itot_pkg::PROD_W-1] ? prod_neg[itot_pkg::MAG_W-1:0]
                                                       : prod_r[itot_pkg::MAG_W-1:0];
  assign div_req.divisor  = den_mag_r;

  itot_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign quo_ext = {1'b0, div_rsp.quotient};

  // Delay is min plus the signed quotient, raised to min and then lowered to max.
  // Because the max clamp comes last, an inverted pair of limits yields max.
  assign lo_ext  = $signed({{(itot_pkg::DELAY_W - itot_pkg::CYCLES_W){1'b0}}, min_trip_r});
  assign hi_ext  = $signed({{(itot_pkg::DELAY_W - itot_pkg::CYCLES_W){1'b0}}, max_trip_r});
  assign dly_raw = lo_ext + $signed({q_r[itot_pkg::QUO_W-1], q_r});
  assign dly_lo  = (dly_raw < lo_ext) ? lo_ext : dly_raw;
  assign dly_clamped = (dly_lo > hi_ext) ? hi_ext : dly_lo;

  assign op_cnt_inc = (operate_count_r < itot_pkg::COUNT_CEILING)
                    ? operate_count_r + itot_pkg::COUNT_W'(1) : itot_pkg::COUNT_CEILING;
  assign rel_dec    = (release_count_r == '0) ? '0
                                              : release_count_r - itot_pkg::CYCLES_W'(1);

  // Sequencer: next state and strobes.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    accept    = 1'b0;
    do_mul    = 1'b0;
    do_dstart = 1'b0;
    ld_q      = 1'b0;
    ld_delay  = 1'b0;
    commit    = 1'b0;
    case (state_r)
      itot_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          accept = 1'b1;
          if (in_data.operation == itot_pkg::OP_EVAL && in_hit) begin
            state_nxt = itot_pkg::ST_MUL;
          end else begin
            state_nxt = itot_pkg::ST_FINISH;
          end
        end
      end
      itot_pkg::ST_MUL: begin
        do_mul    = 1'b1;
        state_nxt = itot_pkg::ST_DSTART;
      end
      itot_pkg::ST_DSTART: begin
        do_dstart = 1'b1;
        state_nxt = itot_pkg::ST_DIV;
      end
      itot_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          ld_q      = 1'b1;
          state_nxt = itot_pkg::ST_CLAMP;
        end
      end
      itot_pkg::ST_CLAMP: begin
        ld_delay  = 1'b1;
        state_nxt = itot_pkg::ST_FINISH;
      end
      itot_pkg::ST_FINISH: begin
        // Wait here only if the previous result has not been taken yet.
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = itot_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itot_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itot_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item working registers; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_data.operation;
      hit_r    <= in_hit;
      sample_r <= in_data.sample;
    end
    if (do_mul) begin
      prod_r    <= prod;
      den_neg_r <= den[itot_pkg::DIFF_W-1];
      if (den == '0) begin
        den_mag_r <= itot_pkg::DEN_W'(1);
      end else if (den[itot_pkg::DIFF_W-1]) begin
        den_mag_r <= den_neg_val[itot_pkg::DEN_W-1:0];
      end else begin
        den_mag_r <= den[itot_pkg::DEN_W-1:0];
      end
    end
    if (do_dstart) begin
      q_neg_r <= prod_r[itot_pkg::PROD_W-1] ^ den_neg_r;
    end
    if (ld_q) begin
      q_r <= q_neg_r ? -$signed(quo_ext) : $signed(quo_ext);
    end
    if (ld_delay) begin
      delay_r <= dly_clamped[itot_pkg::CYCLES_W-1:0];
    end
  end

  // Protection state update and the result register, both at commit; the valid flag drops once the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operate_count_r <= '0;
      release_count_r <= '0;
      pickup_flag_r   <= 1'b0;
      trip_flag_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        if (op_r == itot_pkg::OP_CLEAR) begin
          operate_count_r <= '0;
          release_count_r <= '0;
          pickup_flag_r   <= 1'b0;
          trip_flag_r     <= 1'b0;
        end else if (hit_r) begin
          operate_count_r <= op_cnt_inc;
          release_count_r <= release_cycles_r;
          pickup_flag_r   <= 1'b1;
          if ({1'b0, op_cnt_inc} > delay_r) begin
            trip_flag_r <= 1'b1;
          end
        end else begin
          release_count_r <= rel_dec;
          if (rel_dec == '0) begin
            operate_count_r <= '0;
            pickup_flag_r   <= 1'b0;
            trip_flag_r     <= 1'b0;
          end
        end
      end
    end
  end

  // The result mirrors the state just committed.
  always_comb begin
    out_data_r.trip      = trip_flag_r;
    out_data_r.picked_up = pickup_flag_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A latched trip always comes with pickup held.
  assert property (@(posedge clk) disable iff (!rst_n) trip_flag_r |-> pickup_flag_r)
    else $error("trip latched without pickup");

  // The operate counter never passes its ceiling.
  assert property (@(posedge clk) disable iff (!rst_n)
                   operate_count_r <= itot_pkg::COUNT_CEILING)
    else $error("operate counter above ceiling");

  // The divider only reports completion while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
                   div_rsp.done |-> (state_r == itot_pkg::ST_DIV))
    else $error("divider done outside divide state");

  // After an item is taken the block is not ready in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while previous item in flight");

endmodule

`default_nettype wire
